>>> rtl/lmts_pkg.sv
package lmts_pkg;

    // Width of the mode cycle counter; the sum saturates at its all-ones value.
    localparam int COUNT_BITS = 11;
    localparam int CYC_BITS = 10;
    localparam int LINE_BITS = 8;
    localparam int ELAPSED_BITS = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;
    localparam int CMP_BITS = (COUNT_BITS > CYC_BITS) ? COUNT_BITS : CYC_BITS;
    localparam int SUM_BITS = COUNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_lcd_mode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OAM_SEARCH   = 3'd0,
        REG_TRANSFER     = 3'd1,
        REG_HBLANK       = 3'd2,
        REG_VBLANK_LINE  = 3'd3,
        REG_VISIBLE      = 3'd4,
        REG_LAST_LINE    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [CYC_BITS-1:0]  oam_search_cycles;
        logic [CYC_BITS-1:0]  transfer_cycles;
        logic [CYC_BITS-1:0]  hblank_cycles;
        logic [CYC_BITS-1:0]  vblank_line_cycles;
        logic [LINE_BITS-1:0] visible_lines;
        logic [LINE_BITS-1:0] last_line;
    } t_timing_cfg;

    typedef struct packed {
        t_lcd_mode             mode;
        logic [COUNT_BITS-1:0] count;
        logic [LINE_BITS-1:0]  line;
    } t_seq_state;

    typedef struct packed {
        t_seq_state state;
        logic       vblank_irq;
        logic       render_line;
    } t_step_result;

endpackage

>>> rtl/lmts_step.sv
module lmts_step
    import lmts_pkg::*;
(
    input  t_seq_state              i_state,
    input  t_timing_cfg             i_cfg,
    input  logic [ELAPSED_BITS-1:0] i_elapsed_cycles,
    output t_step_result            o_result
);

    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count_sat;
    logic [CMP_BITS-1:0]   count_cmp;
    logic [LINE_BITS-1:0]  line_inc;
    logic [LINE_BITS:0]    line_next_wide;

    always_comb begin
        sum = SUM_BITS'(i_state.count) + SUM_BITS'(i_elapsed_cycles);
        count_sat = sum[SUM_BITS-1] ? COUNT_MAX : sum[COUNT_BITS-1:0];
        count_cmp = CMP_BITS'(count_sat);
        line_inc = i_state.line + LINE_BITS'(1);
        line_next_wide = (LINE_BITS+1)'(i_state.line) + (LINE_BITS+1)'(1);

        o_result.state = i_state;
        o_result.state.count = count_sat;
        o_result.vblank_irq = 1'b0;
        o_result.render_line = 1'b0;

        case (i_state.mode)
            MODE_HBLANK: begin
                if (count_cmp >= CMP_BITS'(i_cfg.hblank_cycles)) begin
                    o_result.state.count = '0;
                    o_result.state.line = line_inc;
                    if (line_inc == i_cfg.visible_lines) begin
                        o_result.state.mode = MODE_VBLANK;
                        o_result.vblank_irq = 1'b1;
                    end else begin
                        o_result.state.mode = MODE_OAM;
                    end
                end
            end
            MODE_VBLANK: begin
                if (count_cmp >= CMP_BITS'(i_cfg.vblank_line_cycles)) begin
                    o_result.state.count = '0;
                    // The advanced line is compared unwrapped, so line 255 always wraps.
                    if (line_next_wide > (LINE_BITS+1)'(i_cfg.last_line)) begin
                        o_result.state.line = '0;
                        o_result.state.mode = MODE_OAM;
                    end else begin
                        o_result.state.line = line_inc;
                    end
                end
            end
            MODE_OAM: begin
                if (count_cmp >= CMP_BITS'(i_cfg.oam_search_cycles)) begin
                    o_result.state.count = '0;
                    o_result.state.mode = MODE_XFER;
                end
            end
            MODE_XFER: begin
                if (count_cmp >= CMP_BITS'(i_cfg.transfer_cycles)) begin
                    o_result.state.count = '0;
                    o_result.state.mode = MODE_HBLANK;
                    o_result.render_line = 1'b1;
                end
            end
            default: begin
                o_result.state = i_state;
            end
        endcase
    end

endmodule

>>> rtl/lcd_mode_timing_sequencer.sv
// LCD mode timing sequencer.
// Input channel (i_valid/o_ready, i_elapsed_cycles): each transaction carries the
// number of clock cycles that passed since the previous one. The block adds it to
// the mode cycle counter and steps through OAM search, pixel transfer, horizontal
// blank and vertical blank, advancing the line counter.
// Output channel (o_valid/i_ready): one result per input transaction with the new
// mode, the line, a vertical-blank interrupt pulse and a render-line pulse.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
// the six timing registers; it is always ready and should be used while idle.
// The accepting edge loads the input register, and the result register is loaded
// from it once the output side is free. Throughput is one transaction per cycle
// while the receiver keeps i_ready high, set by the state update loop.
// When the receiver stalls, the result register holds, the input register fills,
// and o_ready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, sets horizontal blank,
// clears counter and line, and restores the default timing values.
module lcd_mode_timing_sequencer
    import lmts_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ELAPSED_BITS-1:0]   i_elapsed_cycles,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_lcd_mode,
    output logic [LINE_BITS-1:0]      o_scan_line,
    output logic                      o_vblank_irq,
    output logic                      o_render_line,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_timing_cfg               r_cfg;
    t_seq_state                r_state;
    logic                      r_in_valid;
    logic [ELAPSED_BITS-1:0]   r_elapsed;
    logic                      r_out_valid;
    logic [1:0]                r_lcd_mode;
    logic [LINE_BITS-1:0]      r_scan_line;
    logic                      r_vblank_irq;
    logic                      r_render_line;

    t_step_result              n_step;
    logic                      out_free;
    logic                      step_fire;
    logic                      in_accept;

    lmts_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_elapsed_cycles (r_elapsed),
        .o_result         (n_step)
    );

    assign out_free  = !r_out_valid || i_ready;
    assign step_fire = r_in_valid && out_free;
    assign o_ready   = !r_in_valid || step_fire;
    assign in_accept = i_valid && o_ready;

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_lcd_mode    = r_lcd_mode;
    assign o_scan_line   = r_scan_line;
    assign o_vblank_irq  = r_vblank_irq;
    assign o_render_line = r_render_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oam_search_cycles  <= CYC_BITS'(80);
            r_cfg.transfer_cycles    <= CYC_BITS'(172);
            r_cfg.hblank_cycles      <= CYC_BITS'(204);
            r_cfg.vblank_line_cycles <= CYC_BITS'(456);
            r_cfg.visible_lines      <= LINE_BITS'(144);
            r_cfg.last_line          <= LINE_BITS'(153);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OAM_SEARCH:  r_cfg.oam_search_cycles  <= i_cfg_data[CYC_BITS-1:0];
                REG_TRANSFER:    r_cfg.transfer_cycles    <= i_cfg_data[CYC_BITS-1:0];
                REG_HBLANK:      r_cfg.hblank_cycles      <= i_cfg_data[CYC_BITS-1:0];
                REG_VBLANK_LINE: r_cfg.vblank_line_cycles <= i_cfg_data[CYC_BITS-1:0];
                REG_VISIBLE:     r_cfg.visible_lines      <= i_cfg_data[LINE_BITS-1:0];
                REG_LAST_LINE:   r_cfg.last_line          <= i_cfg_data[LINE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.mode  <= MODE_HBLANK;
            r_state.count <= '0;
            r_state.line  <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end

            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_step.state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_elapsed <= i_elapsed_cycles;
        end
        if (step_fire) begin
            r_lcd_mode    <= n_step.state.mode;
            r_scan_line   <= n_step.state.line;
            r_vblank_irq  <= n_step.vblank_irq;
            r_render_line <= n_step.render_line;
        end
    end

endmodule

>>> dv/lmts_status_checker.sv
module lmts_status_checker
    import lmts_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [ELAPSED_BITS-1:0]   i_elapsed_cycles,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_lcd_mode,
    input  logic [LINE_BITS-1:0]      i_scan_line,
    input  logic                      i_vblank_irq,
    input  logic                      i_render_line,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        t_lcd_mode            mode;
        logic [LINE_BITS-1:0] line;
        logic                 irq;
        logic                 render;
    } t_line_status;

    t_timing_cfg           timing;
    t_lcd_mode             mode;
    logic [COUNT_BITS-1:0] mode_cycles;
    logic [LINE_BITS-1:0]  line;
    t_line_status          awaited_status[$];

    // Adds the elapsed cycles to the mode counter and moves the sequencer on.
    function automatic t_line_status advance_timing(input logic [ELAPSED_BITS-1:0] elapsed);
        logic [SUM_BITS-1:0]  total;
        logic [LINE_BITS:0]   next_line;
        t_line_status         status;
        status.irq = 1'b0;
        status.render = 1'b0;
        total = SUM_BITS'(mode_cycles) + SUM_BITS'(elapsed);
        if (total > SUM_BITS'(COUNT_MAX)) begin
            total = SUM_BITS'(COUNT_MAX);
        end
        mode_cycles = total[COUNT_BITS-1:0];
        case (mode)
            MODE_HBLANK: begin
                if (mode_cycles >= timing.hblank_cycles) begin
                    mode_cycles = '0;
                    line = line + 1'b1;
                    if (line == timing.visible_lines) begin
                        mode = MODE_VBLANK;
                        status.irq = 1'b1;
                    end else begin
                        mode = MODE_OAM;
                    end
                end
            end
            MODE_VBLANK: begin
                if (mode_cycles >= timing.vblank_line_cycles) begin
                    mode_cycles = '0;
                    next_line = {1'b0, line} + 1'b1;
                    // The ninth bit lets a line of 255 run past any last line.
                    if (next_line > {1'b0, timing.last_line}) begin
                        line = '0;
                        mode = MODE_OAM;
                    end else begin
                        line = next_line[LINE_BITS-1:0];
                    end
                end
            end
            MODE_OAM: begin
                if (mode_cycles >= timing.oam_search_cycles) begin
                    mode_cycles = '0;
                    mode = MODE_XFER;
                end
            end
            default: begin
                if (mode_cycles >= timing.transfer_cycles) begin
                    mode_cycles = '0;
                    mode = MODE_HBLANK;
                    status.render = 1'b1;
                end
            end
        endcase
        status.mode = mode;
        status.line = line;
        return status;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_line_status want;
        if (!i_rst_n) begin
            timing.oam_search_cycles = CYC_BITS'(80);
            timing.transfer_cycles = CYC_BITS'(172);
            timing.hblank_cycles = CYC_BITS'(204);
            timing.vblank_line_cycles = CYC_BITS'(456);
            timing.visible_lines = LINE_BITS'(144);
            timing.last_line = LINE_BITS'(153);
            mode = MODE_HBLANK;
            mode_cycles = '0;
            line = '0;
            awaited_status.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_OAM_SEARCH:  timing.oam_search_cycles = i_cfg_data[CYC_BITS-1:0];
                    REG_TRANSFER:    timing.transfer_cycles = i_cfg_data[CYC_BITS-1:0];
                    REG_HBLANK:      timing.hblank_cycles = i_cfg_data[CYC_BITS-1:0];
                    REG_VBLANK_LINE: timing.vblank_line_cycles = i_cfg_data[CYC_BITS-1:0];
                    REG_VISIBLE:     timing.visible_lines = i_cfg_data[LINE_BITS-1:0];
                    REG_LAST_LINE:   timing.last_line = i_cfg_data[LINE_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_status.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual mode %0d line %0d",
                             $time, i_lcd_mode, i_scan_line);
                    o_fail_count++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("lcd_mode", 8'(want.mode), 8'(i_lcd_mode));
                    check_field("scan_line", want.line, i_scan_line);
                    check_field("vblank_irq", 8'(want.irq), 8'(i_vblank_irq));
                    check_field("render_line", 8'(want.render), 8'(i_render_line));
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_status.push_back(advance_timing(i_elapsed_cycles));
            end
        end
        o_pending = awaited_status.size();
    end

endmodule

>>> dv/tb.sv
module tb;
    import lmts_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX_HI = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [ELAPSED_BITS-1:0]   i_elapsed_cycles;
    logic                      o_valid;
    logic                      i_ready;
    logic [1:0]                o_lcd_mode;
    logic [LINE_BITS-1:0]      o_scan_line;
    logic                      o_vblank_irq;
    logic                      o_render_line;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int items_sent = 0;
    int clock_ticks = 0;

    lcd_mode_timing_sequencer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_elapsed_cycles(i_elapsed_cycles),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_lcd_mode      (o_lcd_mode),
        .o_scan_line     (o_scan_line),
        .o_vblank_irq    (o_vblank_irq),
        .o_render_line   (o_render_line),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    lmts_status_checker status_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_elapsed_cycles(i_elapsed_cycles),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_lcd_mode      (o_lcd_mode),
        .i_scan_line     (o_scan_line),
        .i_vblank_irq    (o_vblank_irq),
        .i_render_line   (o_render_line),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        clock_ticks <= clock_ticks + 1;
        if (clock_ticks == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Half small counts so that short thresholds trip often, half over the full range.
    function automatic logic [ELAPSED_BITS-1:0] next_elapsed();
        case ($urandom_range(0, 3))
            0:       return ELAPSED_BITS'($urandom);
            1:       return ELAPSED_BITS'($urandom_range(0, 8));
            2:       return ELAPSED_BITS'($urandom_range(0, 40));
            default: return ELAPSED_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_timing_cfg make_timing(input int oam, input int xfer, input int hbl,
                                                input int vbl, input int vis, input int last);
        t_timing_cfg t;
        t.oam_search_cycles = CYC_BITS'(oam);
        t.transfer_cycles = CYC_BITS'(xfer);
        t.hblank_cycles = CYC_BITS'(hbl);
        t.vblank_line_cycles = CYC_BITS'(vbl);
        t.visible_lines = LINE_BITS'(vis);
        t.last_line = LINE_BITS'(last);
        return t;
    endfunction

    function automatic t_timing_cfg random_timing();
        if ($urandom_range(0, 3) == 0) begin
            return make_timing($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 255), $urandom_range(0, 255));
        end
        return make_timing($urandom_range(0, 48), $urandom_range(0, 48),
                           $urandom_range(0, 48), $urandom_range(0, 48),
                           $urandom_range(0, 10), $urandom_range(0, 14));
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic load_timing(input t_timing_cfg t);
        logic [CFG_DATA_BITS-1:0] vis_word;
        logic [CFG_DATA_BITS-1:0] last_word;
        // Line registers keep only their low bits, so the spare data bits get noise.
        vis_word = CFG_DATA_BITS'($urandom);
        vis_word[LINE_BITS-1:0] = t.visible_lines;
        last_word = CFG_DATA_BITS'($urandom);
        last_word[LINE_BITS-1:0] = t.last_line;
        write_reg(REG_OAM_SEARCH, t.oam_search_cycles);
        write_reg(REG_TRANSFER, t.transfer_cycles);
        write_reg(REG_HBLANK, t.hblank_cycles);
        write_reg(REG_VBLANK_LINE, t.vblank_line_cycles);
        write_reg(REG_VISIBLE, vis_word);
        write_reg(REG_LAST_LINE, last_word);
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? UNUSED_INDEX_HI : UNUSED_INDEX_LO,
                      CFG_DATA_BITS'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Starts and ends on a falling edge; valid stays up across back-to-back items.
    task automatic send_item(input logic [ELAPSED_BITS-1:0] elapsed);
        i_valid <= 1'b1;
        i_elapsed_cycles <= elapsed;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_items(input int count, input bit use_gaps);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) begin
                send_item(next_elapsed());
            end
            left -= burst;
            if (use_gaps && left > 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Receiver: ready in runs of random length, with a long hold-off now and then
    // so that the sequencer backs up and drops o_ready.
    initial begin
        int rounds;
        int high_len;
        int low_len;
        rounds = 0;
        forever begin
            rounds++;
            high_len = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
            i_ready <= 1'b1;
            repeat (high_len) @(negedge i_clk);
            low_len = (rounds % 29 == 7) ? 60 : $urandom_range(0, 5);
            if (low_len > 0) begin
                i_ready <= 1'b0;
                repeat (low_len) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [ELAPSED_BITS-1:0] opening[$];
        opening = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'h55, 8'hAA,
                    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                    8'd255, 8'd0, 8'd255, 8'd255, 8'd255};
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_elapsed_cycles <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default timing after reset.
        foreach (opening[k]) begin
            send_item(opening[k]);
        end
        i_valid <= 1'b0;

        // Zero thresholds: every step changes the mode or, in vertical blank, the line.
        wait_idle();
        load_timing(make_timing(0, 0, 0, 0, 3, 5));
        run_items(40, 1'b1);

        // Last line below visible lines: vertical blank lasts one line.
        wait_idle();
        load_timing(make_timing(2, 3, 4, 5, 6, 2));
        run_items(80, 1'b1);

        // A long vertical blank that climbs to line 255 and wraps to zero.
        wait_idle();
        load_timing(make_timing(0, 0, 0, 0, 1, 255));
        run_items(280, 1'b0);

        wait_idle();
        load_timing(make_timing(1023, 1023, 1023, 1023, 255, 255));
        run_items(100, 1'b1);

        wait_idle();
        load_timing(make_timing(1, 1, 1, 1, 1, 1));
        run_items(60, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            load_timing(random_timing());
            run_items($urandom_range(90, 180), $urandom_range(0, 3) != 0);
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
